// ===== rtl/txcps_pkg.sv =====
// shared constants and types for the transmit class scheduler
package txcps_pkg;
    localparam int RELIABLE_SLOTS = 8;
    localparam int LATEST_SLOTS = 8;
    localparam int SAMPLE_SLOTS = 8;
    localparam int BULK_SLOTS = 8;
    localparam int TOTAL_SLOTS = RELIABLE_SLOTS + LATEST_SLOTS + SAMPLE_SLOTS + BULK_SLOTS;
    localparam int SLOT_W = $clog2(TOTAL_SLOTS + 1);
    localparam int CNT_W = 6;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_OVERSIZE = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;
    localparam logic [2:0] ST_NO_ROOM = 3'd5;

    localparam logic [1:0] CLS_RELIABLE = 2'd0;
    localparam logic [1:0] CLS_LATEST = 2'd1;
    localparam logic [1:0] CLS_SAMPLE = 2'd2;
    localparam logic [1:0] CLS_BULK = 2'd3;

    localparam logic OP_ENQ = 1'b0;

    typedef struct packed {
        logic [31:0] key;
        logic [2:0]  prio;
        logic [31:0] deadline;
        logic        has_dl;
        logic [31:0] seq;
        logic [15:0] length;
        logic [31:0] tag;
    } slot_t;
    localparam int SLOT_DW = $bits(slot_t);

    typedef struct packed {
        logic        opcode;
        logic [1:0]  storage_class;
        logic [2:0]  msg_priority;
        logic [15:0] deadline_span;
        logic [31:0] msg_key;
        logic [31:0] payload_tag;
        logic [15:0] msg_length;
        logic [31:0] now_time;
        logic [15:0] room_available;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_tag;
        logic [15:0] out_length;
        logic [5:0]  pending_count;
    } rsp_t;

    function automatic logic [SLOT_W-1:0] class_base(input logic [1:0] c);
        case (c)
            CLS_RELIABLE: class_base = '0;
            CLS_LATEST: class_base = SLOT_W'(RELIABLE_SLOTS);
            CLS_SAMPLE: class_base = SLOT_W'(RELIABLE_SLOTS + LATEST_SLOTS);
            default: class_base = SLOT_W'(RELIABLE_SLOTS + LATEST_SLOTS + SAMPLE_SLOTS);
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] class_end(input logic [1:0] c);
        case (c)
            CLS_RELIABLE: class_end = SLOT_W'(RELIABLE_SLOTS);
            CLS_LATEST: class_end = SLOT_W'(RELIABLE_SLOTS + LATEST_SLOTS);
            CLS_SAMPLE: class_end = SLOT_W'(RELIABLE_SLOTS + LATEST_SLOTS + SAMPLE_SLOTS);
            default: class_end = SLOT_W'(TOTAL_SLOTS);
        endcase
    endfunction
endpackage

// ===== rtl/txcps_if.sv =====
// valid/ready channel interfaces for request and response
interface txcps_req_if;
    import txcps_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface txcps_rsp_if;
    import txcps_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/txcps_ram.sv =====
// generic single-port ram with registered read
module txcps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/tx_class_priority_scheduler.sv =====
// transmit class scheduler top level: sequencer, slot ram and shared compare unit
// an enqueue scans the 8 slots of its class, a take scans up to all 32 slots class by
// class; every slot passes through an address state and an evaluate state
// one request at a time; in.ready is low from acceptance until the response is taken
// reset clears valid bits and pending count and sets the sequence counter to one;
// slot ram contents are not cleared, as valid bits mask unwritten entries
module tx_class_priority_scheduler (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    txcps_req_if.sink in,
    txcps_rsp_if.source out
);
    import txcps_pkg::*;

    localparam int AW = $clog2(TOTAL_SLOTS);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // issue address
    localparam logic [2:0] S_EVAL = 3'd2;  // data available
    localparam logic [2:0] S_DEC = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_RSP = 3'd5;
    localparam logic [2:0] S_FETCH = 3'd6; // read selected slot for take
    localparam logic [2:0] S_FWAIT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [15:0] max_len_reg [4];
    logic [TOTAL_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic [31:0] seq_reg, seq_next;
    req_t req_reg, req_next;
    logic [1:0] cls_reg, cls_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [AW-1:0] addr_reg, addr_next;
    // enqueue finds
    logic key_hit_reg, key_hit_next, free_hit_reg, free_hit_next;
    logic [AW-1:0] key_s_reg, key_s_next, free_s_reg, free_s_next;
    // best pick (oldest or take selection)
    logic sel_hit_reg, sel_hit_next;
    logic [AW-1:0] sel_s_reg, sel_s_next;
    logic [2:0] sel_prio_reg, sel_prio_next;
    logic [31:0] sel_seq_reg, sel_seq_next;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    slot_t ram_wdata, ram_rdata;

    txcps_ram #(.WIDTH(SLOT_DW), .DEPTH(1 << AW)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    // a new request waits until the previous response has left the output register
    assign in.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign out.valid = rsp_valid_reg;
    assign out.data = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                max_len_reg[i] <= 16'd256;
            end
        end
        else if (cfg_we)
        begin
            max_len_reg[cfg_index] <= cfg_data;
        end
    end

    // shared compare unit: evaluates one slot at a time, the slot whose read S_SCAN issued
    logic cur_valid, cur_expired, better, oldest;
    logic [31:0] age;
    always_comb
    begin
        cur_valid = valid_reg[addr_reg];
        age = req_reg.now_time - ram_rdata.deadline;
        cur_expired = ram_rdata.has_dl && !age[31];
        oldest = ram_rdata.seq < sel_seq_reg;
        if (req_reg.opcode == OP_ENQ)
        begin
            better = !sel_hit_reg || oldest;
        end
        else
        begin
            better = !sel_hit_reg
                || (cls_reg < CLS_SAMPLE && ram_rdata.prio > sel_prio_reg)
                || (ram_rdata.prio == sel_prio_reg && oldest);
        end
    end

    logic len_over;
    assign len_over = req_reg.msg_length > max_len_reg[req_reg.storage_class];

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        pend_next = pend_reg;
        seq_next = seq_reg;
        req_next = req_reg;
        cls_next = cls_reg;
        idx_next = idx_reg;
        addr_next = addr_reg;
        key_hit_next = key_hit_reg;
        key_s_next = key_s_reg;
        free_hit_next = free_hit_reg;
        free_s_next = free_s_reg;
        sel_hit_next = sel_hit_reg;
        sel_s_next = sel_s_reg;
        sel_prio_next = sel_prio_reg;
        sel_seq_next = sel_seq_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we = 1'b0;
        ram_addr = addr_reg;
        ram_wdata = ram_rdata;
        if (rsp_valid_reg && out.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in.valid && !rsp_valid_reg)
                begin
                    req_next = in.data;
                    key_hit_next = 1'b0;
                    free_hit_next = 1'b0;
                    sel_hit_next = 1'b0;
                    rsp_next.out_tag = '0;
                    rsp_next.out_length = '0;
                    if (in.data.opcode == OP_ENQ)
                    begin
                        cls_next = in.data.storage_class;
                        idx_next = class_base(in.data.storage_class);
                        if (in.data.msg_length == '0)
                        begin
                            rsp_next.status = ST_ZERO;
                            state_next = S_RSP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        cls_next = CLS_RELIABLE;
                        idx_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg == class_end(cls_reg))
                begin
                    if (req_reg.opcode == OP_ENQ || sel_hit_reg || cls_reg == CLS_BULK)
                    begin
                        state_next = S_DEC;
                    end
                    else
                    begin
                        cls_next = cls_reg + 2'd1;
                    end
                end
                else
                begin
                    ram_addr = idx_reg[AW-1:0];
                    addr_next = idx_reg[AW-1:0];
                    idx_next = idx_reg + 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_SCAN;
                if (cur_valid)
                begin
                    if (req_reg.opcode == OP_ENQ)
                    begin
                        if (!key_hit_reg && ram_rdata.key == req_reg.msg_key)
                        begin
                            key_hit_next = 1'b1;
                            key_s_next = addr_reg;
                        end
                        if (better)
                        begin
                            sel_hit_next = 1'b1;
                            sel_s_next = addr_reg;
                            sel_seq_next = ram_rdata.seq;
                        end
                    end
                    else if (cur_expired)
                    begin
                        valid_next[addr_reg] = 1'b0;
                        pend_next = pend_reg - 1'b1;
                    end
                    else if (better)
                    begin
                        sel_hit_next = 1'b1;
                        sel_s_next = addr_reg;
                        sel_prio_next = ram_rdata.prio;
                        sel_seq_next = ram_rdata.seq;
                    end
                end
                else if (!free_hit_reg)
                begin
                    free_hit_next = 1'b1;
                    free_s_next = addr_reg;
                end
            end
            S_DEC:
            begin
                if (req_reg.opcode == OP_ENQ)
                begin
                    state_next = S_RSP;
                    if (cls_reg == CLS_LATEST && key_hit_reg)
                    begin
                        addr_next = key_s_reg;
                    end
                    else if (free_hit_reg)
                    begin
                        addr_next = free_s_reg;
                    end
                    else
                    begin
                        addr_next = sel_s_reg;
                    end
                    if ((cls_reg == CLS_RELIABLE || cls_reg == CLS_BULK) && !free_hit_reg)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else if (len_over)
                    begin
                        rsp_next.status = ST_OVERSIZE;
                    end
                    else
                    begin
                        rsp_next.status = ST_OK;
                        state_next = S_WRITE;
                    end
                end
                else if (!sel_hit_reg)
                begin
                    rsp_next.status = ST_NONE;
                    state_next = S_RSP;
                end
                else
                begin
                    addr_next = sel_s_reg;
                    state_next = S_FETCH;
                end
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                ram_wdata.key = req_reg.msg_key;
                ram_wdata.prio = req_reg.msg_priority;
                ram_wdata.has_dl = req_reg.deadline_span != '0;
                ram_wdata.deadline = req_reg.now_time + {16'd0, req_reg.deadline_span};
                ram_wdata.seq = seq_reg;
                ram_wdata.length = req_reg.msg_length;
                ram_wdata.tag = req_reg.payload_tag;
                seq_next = seq_reg + 32'd1;
                if (!valid_reg[addr_reg])
                begin
                    pend_next = pend_reg + 1'b1;
                end
                valid_next[addr_reg] = 1'b1;
                state_next = S_RSP;
            end
            S_FETCH:
            begin
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (req_reg.room_available < ram_rdata.length)
                begin
                    rsp_next.status = ST_NO_ROOM;
                end
                else
                begin
                    rsp_next.status = ST_OK;
                    rsp_next.out_tag = ram_rdata.tag;
                    rsp_next.out_length = ram_rdata.length;
                    valid_next[addr_reg] = 1'b0;
                    pend_next = pend_reg - 1'b1;
                end
                state_next = S_RSP;
            end
            default:
            begin
                // S_RSP: wait for the output register to be free
                if (!rsp_valid_next)
                begin
                    rsp_next.pending_count = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            pend_reg <= '0;
            seq_reg <= 32'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pend_reg <= pend_next;
            seq_reg <= seq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        cls_reg <= cls_next;
        idx_reg <= idx_next;
        addr_reg <= addr_next;
        key_hit_reg <= key_hit_next;
        key_s_reg <= key_s_next;
        free_hit_reg <= free_hit_next;
        free_s_reg <= free_s_next;
        sel_hit_reg <= sel_hit_next;
        sel_s_reg <= sel_s_next;
        sel_prio_reg <= sel_prio_next;
        sel_seq_reg <= sel_seq_next;
        rsp_reg <= rsp_next;
    end
endmodule
